// ===== sv/tcw_pkg.sv =====
// Shared constants, codes and types of the text console writer.
`default_nettype none
package tcw_pkg;
   localparam int unsigned COLUMNS_DEFAULT = 80;
   localparam int unsigned ROWS_DEFAULT    = 25;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned SYM_W    = 8;
   localparam int unsigned COLOR_W  = 8;
   localparam int unsigned INDEX_W  = 11;
   localparam int unsigned CURSOR_W = 11;
   localparam int unsigned CELL_W   = SYM_W + COLOR_W;

   localparam logic [SYM_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [SYM_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [SYM_W-1:0] CH_SPACE     = 8'd32;
   localparam logic [SYM_W-1:0] CH_BLANK     = 8'd0;

   localparam logic [COLOR_W-1:0] FILL_RESET = 8'd2;

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_DONE,
      ST_COPY,
      ST_FILL,
      ST_CLEAR
   } state_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_ADVANCE,
      CUR_BACK,
      CUR_NEWLINE,
      CUR_TO_LAST,
      CUR_HOME
   } cur_cmd_type;

   typedef struct packed {
      logic at_home;
      logic at_end;
      logic on_last_row;
   } cur_status_type;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [SYM_W-1:0]   symbol;
      logic [COLOR_W-1:0] color;
      logic [INDEX_W-1:0] cell_index;
   } req_item_type;
endpackage
`default_nettype wire

// ===== sv/tcw_req_if.sv =====
// Request channel of the text console writer.
`default_nettype none
interface tcw_req_if;
   import tcw_pkg::*;
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [SYM_W-1:0]   symbol;
   logic [COLOR_W-1:0] color;
   logic [INDEX_W-1:0] cell_index;

   modport source (output valid, output operation, output symbol, output color,
                   output cell_index, input ready);
   modport sink (input valid, input operation, input symbol, input color,
                 input cell_index, output ready);
endinterface
`default_nettype wire

// ===== sv/tcw_rsp_if.sv =====
// Response channel of the text console writer.
`default_nettype none
interface tcw_rsp_if;
   import tcw_pkg::*;
   logic                valid;
   logic                ready;
   logic [CURSOR_W-1:0] cursor;
   logic [SYM_W-1:0]    cell_symbol;
   logic [COLOR_W-1:0]  cell_color;

   modport source (output valid, output cursor, output cell_symbol, output cell_color,
                   input ready);
   modport sink (input valid, input cursor, input cell_symbol, input cell_color,
                 output ready);
endinterface
`default_nettype wire

// ===== sv/tcw_cursor.sv =====
// Cursor register with its column and row-start trackers.
`default_nettype none
module tcw_cursor #(
   parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT,
   localparam int unsigned TOTAL  = COLUMNS * ROWS,
   localparam int unsigned CUR_W  = $clog2(TOTAL + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tcw_pkg::cur_cmd_type   cmd,
   output logic [CUR_W-1:0]            cursor,
   output logic [CUR_W-1:0]            cursor_next,
   output tcw_pkg::cur_status_type     status
);
   import tcw_pkg::*;

   localparam int unsigned LAST  = (ROWS - 1) * COLUMNS;
   localparam int unsigned COL_W = $clog2(COLUMNS);

   logic [CUR_W-1:0] cursor_ff, cursor_in;
   logic [CUR_W-1:0] base_ff, base_in;
   logic [COL_W-1:0] col_ff, col_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         base_ff   <= '0;
         col_ff    <= '0;
      end else begin
         cursor_ff <= cursor_in;
         base_ff   <= base_in;
         col_ff    <= col_in;
      end
   end

   always_comb begin
      cursor_in = cursor_ff;
      base_in   = base_ff;
      col_in    = col_ff;
      unique case (cmd)
         CUR_HOLD: begin
         end
         CUR_ADVANCE: begin
            cursor_in = cursor_ff + CUR_W'(1);
            if (col_ff == COL_W'(COLUMNS - 1)) begin
               col_in  = '0;
               base_in = base_ff + CUR_W'(COLUMNS);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         CUR_BACK: begin
            cursor_in = cursor_ff - CUR_W'(1);
            if (col_ff == '0) begin
               col_in  = COL_W'(COLUMNS - 1);
               base_in = base_ff - CUR_W'(COLUMNS);
            end else begin
               col_in = col_ff - COL_W'(1);
            end
         end
         CUR_NEWLINE: begin
            cursor_in = base_ff + CUR_W'(COLUMNS);
            base_in   = base_ff + CUR_W'(COLUMNS);
            col_in    = '0;
         end
         CUR_TO_LAST: begin
            cursor_in = CUR_W'(LAST);
            base_in   = CUR_W'(LAST);
            col_in    = '0;
         end
         CUR_HOME: begin
            cursor_in = '0;
            base_in   = '0;
            col_in    = '0;
         end
         default: begin
         end
      endcase
   end

   assign cursor             = cursor_ff;
   assign cursor_next        = cursor_in;
   assign status.at_home     = (cursor_ff == '0);
   assign status.at_end      = (cursor_ff == CUR_W'(TOTAL));
   assign status.on_last_row = (cursor_ff >= CUR_W'(LAST));
endmodule
`default_nettype wire

// ===== sv/tcw_engine.sv =====
// Sequencer and screen cell memory: writes, reads, scroll copy and blanking sweeps.
`default_nettype none
module tcw_engine #(
   parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT,
   localparam int unsigned TOTAL  = COLUMNS * ROWS,
   localparam int unsigned CUR_W  = $clog2(TOTAL + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire tcw_pkg::req_item_type         req_item,
   input  wire logic [tcw_pkg::COLOR_W-1:0]   fill_color,
   input  wire logic                          out_free,
   input  wire logic [CUR_W-1:0]              cursor,
   input  wire logic [CUR_W-1:0]              cursor_next,
   input  wire tcw_pkg::cur_status_type       cur_status,
   output tcw_pkg::cur_cmd_type               cur_cmd,
   output logic                               rsp_load,
   output logic [CUR_W-1:0]                   rsp_cursor,
   output logic [tcw_pkg::SYM_W-1:0]          rsp_symbol,
   output logic [tcw_pkg::COLOR_W-1:0]        rsp_color
);
   import tcw_pkg::*;

   localparam int unsigned LAST   = (ROWS - 1) * COLUMNS;
   localparam int unsigned ADDR_W = $clog2(TOTAL);

   logic [CELL_W-1:0] screen_mem [TOTAL];

   state_type         state_ff, state_in;
   req_item_type      item_ff, item_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              copy_wr_ff, copy_wr_in;
   logic [ADDR_W-1:0] copy_addr_ff, copy_addr_in;
   logic [CELL_W-1:0] rd_data_ff;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic              finish;
   logic              in_range;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         cnt_ff     <= '0;
         copy_wr_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         copy_wr_ff <= copy_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      copy_addr_ff <= copy_addr_in;
   end

   assign in_range = (32'(item_ff.cell_index) < 32'(TOTAL));

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      copy_wr_in   = 1'b0;
      copy_addr_in = copy_addr_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      cur_cmd      = CUR_HOLD;
      req_ready    = 1'b0;
      rsp_load     = 1'b0;
      rsp_cursor   = cursor;
      rsp_symbol   = '0;
      rsp_color    = '0;
      finish       = 1'b0;

      // drain the copy write, issued in the cycle after its read
      if (copy_wr_ff) begin
         mem_we    = 1'b1;
         mem_waddr = copy_addr_ff;
         mem_wdata = rd_data_ff;
      end

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = {CH_BLANK, FILL_RESET};
            if (cnt_ff == ADDR_W'(TOTAL - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (op_type'(item_ff.operation))
               OP_PUT: begin
                  if (item_ff.symbol == CH_NEWLINE) begin
                     if (cur_status.on_last_row) begin
                        cnt_in   = '0;
                        state_in = ST_COPY;
                     end else begin
                        cur_cmd = CUR_NEWLINE;
                        finish  = 1'b1;
                     end
                  end else if (item_ff.symbol == CH_BACKSPACE) begin
                     if (!cur_status.at_home) begin
                        cur_cmd   = CUR_BACK;
                        mem_we    = 1'b1;
                        mem_waddr = ADDR_W'(cursor_next);
                        mem_wdata = {CH_SPACE, item_ff.color};
                     end
                     finish = 1'b1;
                  end else if (cur_status.at_end) begin
                     // scroll first, then come back here to place the byte
                     cnt_in   = '0;
                     state_in = ST_COPY;
                  end else begin
                     cur_cmd   = CUR_ADVANCE;
                     mem_we    = 1'b1;
                     mem_waddr = ADDR_W'(cursor);
                     mem_wdata = {item_ff.symbol, item_ff.color};
                     finish    = 1'b1;
                  end
               end
               OP_CLEAR: begin
                  cnt_in   = '0;
                  state_in = ST_CLEAR;
               end
               OP_READ: begin
                  if (in_range) begin
                     mem_re    = 1'b1;
                     mem_raddr = ADDR_W'(item_ff.cell_index);
                  end
                  state_in = ST_DONE;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if ((op_type'(item_ff.operation) == OP_READ) && in_range) begin
                  rsp_symbol = rd_data_ff[CELL_W-1 -: SYM_W];
                  rsp_color  = rd_data_ff[COLOR_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            mem_re       = 1'b1;
            mem_raddr    = ADDR_W'(32'(cnt_ff) + 32'(COLUMNS));
            copy_wr_in   = 1'b1;
            copy_addr_in = cnt_ff;
            if (cnt_ff == ADDR_W'(LAST - 1)) begin
               cnt_in   = '0;
               state_in = ST_FILL;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_FILL: begin
            if (!copy_wr_ff) begin
               mem_we    = 1'b1;
               mem_waddr = ADDR_W'(32'(LAST) + 32'(cnt_ff));
               mem_wdata = {CH_BLANK, fill_color};
               if (cnt_ff == ADDR_W'(COLUMNS - 1)) begin
                  cur_cmd  = CUR_TO_LAST;
                  cnt_in   = '0;
                  state_in = (item_ff.symbol == CH_NEWLINE) ? ST_DONE : ST_EXEC;
               end else begin
                  cnt_in = cnt_ff + ADDR_W'(1);
               end
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = {CH_BLANK, fill_color};
            if (cnt_ff == ADDR_W'(TOTAL - 1)) begin
               cur_cmd  = CUR_HOME;
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // report right away when the output register can take it
      if (finish) begin
         if (out_free) begin
            rsp_load   = 1'b1;
            rsp_cursor = cursor_next;
            state_in   = ST_IDLE;
         end else begin
            state_in = ST_DONE;
         end
      end
   end
endmodule
`default_nettype wire

// ===== sv/text_console_writer.sv =====
// Text console writer top level: ROWS x COLUMNS character/attribute screen with a cursor.
// Each request transaction (put character, clear screen, read cell) yields exactly one
// response transaction carrying the cursor after the operation and, for a read, the
// cell contents. The screen lives in a single-port-write, one-read synchronous memory.
// A put character writes one cell, moves the cursor or does nothing; clear screen sweeps
// every cell; a newline on the last row, or a printable byte with the cursor past the
// end, scrolls by copying (ROWS-1)*COLUMNS cells and blanking one row. After reset a
// clearing pass over all ROWS*COLUMNS cells (2000 at 80 x 25) runs with req_chan.ready
// low; csr writes are taken at any time. The response is held in an output register,
// so the next request is accepted while a response still waits. csr_write_data sets
// the fill attribute for cleared and scrolled-in cells and should be written only while
// the block is idle.
`default_nettype none
module text_console_writer #(
   parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   tcw_req_if.sink                          req_chan,
   tcw_rsp_if.source                        rsp_chan,
   input  wire logic                        csr_write_enable,
   input  wire logic [tcw_pkg::COLOR_W-1:0] csr_write_data
);
   import tcw_pkg::*;

   localparam int unsigned TOTAL = COLUMNS * ROWS;
   localparam int unsigned CUR_W = $clog2(TOTAL + 1);
   localparam int unsigned EXT_W = (CUR_W > CURSOR_W) ? CUR_W : CURSOR_W;

   logic [COLOR_W-1:0]  fill_color_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic [SYM_W-1:0]    rsp_symbol_ff, rsp_symbol_in;
   logic [COLOR_W-1:0]  rsp_color_ff, rsp_color_in;

   req_item_type        req_item;
   logic                out_free;
   logic                eng_ready;
   logic                eng_load;
   logic [CUR_W-1:0]    eng_cursor;
   logic [SYM_W-1:0]    eng_symbol;
   logic [COLOR_W-1:0]  eng_color;
   logic [CUR_W-1:0]    cursor;
   logic [CUR_W-1:0]    cursor_next;
   cur_status_type      cur_status;
   cur_cmd_type         cur_cmd;
   logic [EXT_W-1:0]    cursor_ext;

   always_comb begin
      req_item.operation  = req_chan.operation;
      req_item.symbol     = req_chan.symbol;
      req_item.color      = req_chan.color;
      req_item.cell_index = req_chan.cell_index;
   end

   assign req_chan.ready = eng_ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   tcw_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (eng_ready),
      .req_item    (req_item),
      .fill_color  (fill_color_ff),
      .out_free    (out_free),
      .cursor      (cursor),
      .cursor_next (cursor_next),
      .cur_status  (cur_status),
      .cur_cmd     (cur_cmd),
      .rsp_load    (eng_load),
      .rsp_cursor  (eng_cursor),
      .rsp_symbol  (eng_symbol),
      .rsp_color   (eng_color)
   );

   tcw_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cur_cmd),
      .cursor      (cursor),
      .cursor_next (cursor_next),
      .status      (cur_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_color_ff <= FILL_RESET;
      end else if (csr_write_enable) begin
         fill_color_ff <= csr_write_data;
      end
   end

   // the cursor field carries the low bits of the position
   assign cursor_ext    = EXT_W'(eng_cursor);
   assign rsp_cursor_in = eng_load ? cursor_ext[CURSOR_W-1:0] : rsp_cursor_ff;
   assign rsp_symbol_in = eng_load ? eng_symbol : rsp_symbol_ff;
   assign rsp_color_in  = eng_load ? eng_color : rsp_color_ff;

   always_comb begin
      priority if (eng_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_color_ff  <= rsp_color_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cursor      = rsp_cursor_ff;
   assign rsp_chan.cell_symbol = rsp_symbol_ff;
   assign rsp_chan.cell_color  = rsp_color_ff;
endmodule
`default_nettype wire

// ===== sv/tcw_checker.sv =====
// Port-level checks of the text console writer and their bind to the top level.
`default_nettype none
module tcw_checker #(
   parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [tcw_pkg::CURSOR_W-1:0] rsp_cursor,
   input wire logic [tcw_pkg::SYM_W-1:0]    rsp_cell_symbol,
   input wire logic [tcw_pkg::COLOR_W-1:0]  rsp_cell_color
);
   import tcw_pkg::*;

   localparam int unsigned TOTAL = COLUMNS * ROWS;

   logic       req_take;
   logic       rsp_take;
   logic [1:0] open_ff, open_in;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // count transactions taken in but not yet answered
   always_comb begin
      open_in = open_ff;
      if (req_take && !rsp_take) begin
         open_in = open_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_cursor) && $stable(rsp_cell_symbol)
                                  && $stable(rsp_cell_color))
      else $error("response payload changed while stalled");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response without an outstanding request");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("more than two requests outstanding");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_cursor) <= 32'(TOTAL))
      else $error("cursor beyond end of screen");
endmodule

bind text_console_writer tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_cursor      (rsp_chan.cursor),
   .rsp_cell_symbol (rsp_chan.cell_symbol),
   .rsp_cell_color  (rsp_chan.cell_color)
);
`default_nettype wire

// ===== verif/text_console_writer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the text console writer: directed and random text streams.
module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int unsigned COLS           = COLUMNS_DEFAULT;
   localparam int unsigned LINES          = ROWS_DEFAULT;
   localparam int unsigned SCREEN_CELLS   = COLS * LINES;
   localparam int unsigned LAST_ROW_START = (LINES - 1) * COLS;
   localparam int unsigned INDEX_MAX      = (1 << INDEX_W) - 1;
   localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
   localparam int unsigned STALL_LIMIT    = 15000;
   localparam int unsigned HOLD_AFTER     = 260;
   localparam int unsigned HOLD_CYCLES    = 600;
   localparam int unsigned DRAIN_CYCLES   = 16;
   localparam int unsigned MAX_REPORTS    = 10;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor;
      logic [SYM_W-1:0]    cell_symbol;
      logic [COLOR_W-1:0]  cell_color;
   } console_reply_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_MOSTLY,
      RX_SPARSE,
      RX_PERIODIC
   } rx_mode_type;

   class console_scoreboard;
      logic [SYM_W-1:0]   glyph [SCREEN_CELLS];
      logic [COLOR_W-1:0] attr  [SCREEN_CELLS];
      int unsigned        cursor;
      logic [COLOR_W-1:0] fill;
      console_reply_type  replies [$];
      int unsigned        mismatches;
      int unsigned        checked;
      int unsigned        scrolls;
      int unsigned        clears;
      int unsigned        reads;
      int unsigned        far_reads;

      function new();
         fill = FILL_RESET;
         cursor = 0;
         blank_screen();
      endfunction

      function void blank_screen();
         foreach (glyph[i]) begin
            glyph[i] = CH_BLANK;
            attr[i] = fill;
         end
      endfunction

      function void scroll_up();
         for (int unsigned i = 0; i < LAST_ROW_START; i++) begin
            glyph[i] = glyph[i + COLS];
            attr[i] = attr[i + COLS];
         end
         for (int unsigned i = LAST_ROW_START; i < SCREEN_CELLS; i++) begin
            glyph[i] = CH_BLANK;
            attr[i] = fill;
         end
         cursor = LAST_ROW_START;
         scrolls++;
      endfunction

      function void note_request(input req_item_type it);
         console_reply_type r;
         int unsigned pos;
         r = '0;
         pos = cursor;
         case (it.operation)
            OP_PUT: begin
               if (it.symbol == CH_NEWLINE) begin
                  if (pos / COLS >= LINES - 1) scroll_up();
                  else cursor = pos - pos % COLS + COLS;
               end else if (it.symbol == CH_BACKSPACE) begin
                  if (pos >= 1) begin
                     cursor = pos - 1;
                     glyph[pos - 1] = CH_SPACE;
                     attr[pos - 1] = it.color;
                  end
               end else begin
                  // past the end: scroll first, then write at the last row start
                  if (pos >= SCREEN_CELLS) begin
                     scroll_up();
                     pos = cursor;
                  end
                  glyph[pos] = it.symbol;
                  attr[pos] = it.color;
                  cursor = pos + 1;
               end
            end
            OP_CLEAR: begin
               blank_screen();
               cursor = 0;
               clears++;
            end
            OP_READ: begin
               reads++;
               if (it.cell_index < SCREEN_CELLS) begin
                  r.cell_symbol = glyph[it.cell_index];
                  r.cell_color = attr[it.cell_index];
               end else begin
                  far_reads++;
               end
            end
            default: ;
         endcase
         r.cursor = CURSOR_W'(cursor);
         replies.push_back(r);
      endfunction

      function void check_response(input console_reply_type got);
         console_reply_type want;
         checked++;
         if (replies.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: cursor %0d symbol %02h color %02h",
                        got.cursor, got.cell_symbol, got.cell_color);
            return;
         end
         want = replies.pop_front();
         if (got.cursor !== want.cursor || got.cell_symbol !== want.cell_symbol ||
             got.cell_color !== want.cell_color) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $write("mismatch on response %0d: expected cursor %0d symbol %02h color %02h, ",
                      checked, want.cursor, want.cell_symbol, want.cell_color);
               $display("got cursor %0d symbol %02h color %02h",
                        got.cursor, got.cell_symbol, got.cell_color);
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [COLOR_W-1:0]  csr_write_data = '0;

   tcw_req_if req_chan ();
   tcw_rsp_if rsp_chan ();

   console_scoreboard sb;
   int unsigned       items_sent;
   int unsigned       burst_left;
   bit                offering;
   int unsigned       quiet_cycles;
   int unsigned       hold_left;
   bit                hold_done;
   int unsigned       mode_left;
   int unsigned       rx_tick;
   rx_mode_type       rx_mode;
   logic [COLOR_W-1:0] last_fill;

   text_console_writer dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic req_item_type make_item(input logic [OP_W-1:0] op,
                                              input logic [SYM_W-1:0] sym,
                                              input logic [COLOR_W-1:0] color,
                                              input logic [INDEX_W-1:0] idx);
      req_item_type it;
      it.operation = op;
      it.symbol = sym;
      it.color = color;
      it.cell_index = idx;
      return it;
   endfunction

   function automatic logic [SYM_W-1:0] pick_glyph();
      logic [SYM_W-1:0] g;
      do g = SYM_W'($urandom); while (g == CH_NEWLINE || g == CH_BACKSPACE);
      return g;
   endfunction

   // mostly cells just behind the cursor, where text was written
   function automatic logic [INDEX_W-1:0] pick_index();
      int unsigned back;
      int unsigned sel;
      back = $urandom_range(1, 160);
      sel = $urandom_range(0, 19);
      if (sel < 12 && sb.cursor >= back) return INDEX_W'(sb.cursor - back);
      if (sel < 17) return INDEX_W'($urandom_range(0, SCREEN_CELLS - 1));
      return INDEX_W'($urandom_range(SCREEN_CELLS, INDEX_MAX));
   endfunction

   task automatic send_item(input req_item_type it);
      req_chan.valid      <= 1'b1;
      req_chan.operation  <= it.operation;
      req_chan.symbol     <= it.symbol;
      req_chan.color      <= it.color;
      req_chan.cell_index <= it.cell_index;
      offering = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(it);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(0, 4) == 0 ? $urandom_range(9, 30) : $urandom_range(1, 8))
            @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
      end
   endtask

   task automatic put_byte(input logic [SYM_W-1:0] sym);
      send_item(make_item(OP_PUT, sym, COLOR_W'($urandom), INDEX_W'($urandom)));
   endtask

   task automatic read_cell(input logic [INDEX_W-1:0] idx);
      send_item(make_item(OP_READ, SYM_W'($urandom), COLOR_W'($urandom), idx));
   endtask

   // drop valid and wait until every response has been checked
   task automatic settle();
      if (offering) begin
         req_chan.valid <= 1'b0;
         offering = 1'b0;
      end
      while (sb.replies.size() != 0) @(posedge clock);
   endtask

   task automatic set_fill(input logic [COLOR_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.fill = value;
      last_fill = value;
   endtask

   task automatic run_text(input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned k;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100) : $urandom_range(0, 6);
            repeat (k) put_byte(pick_glyph());
            put_byte(CH_NEWLINE);
         end else if (pick < 48) begin
            // run the last row out to the end, then push one more transaction past it
            if (sb.cursor >= LAST_ROW_START) begin
               while (sb.cursor < SCREEN_CELLS) put_byte(pick_glyph());
               case ($urandom_range(0, 3))
                  0: put_byte(pick_glyph());
                  1: put_byte(CH_NEWLINE);
                  2: put_byte(CH_BACKSPACE);
                  default: read_cell(INDEX_W'(SCREEN_CELLS - 1));
               endcase
            end
         end else if (pick < 63) begin
            repeat ($urandom_range(1, 3)) read_cell(pick_index());
         end else if (pick < 73) begin
            repeat ($urandom_range(1, 5)) put_byte(CH_BACKSPACE);
            repeat ($urandom_range(0, 3)) put_byte(pick_glyph());
         end else if (pick < 77) begin
            send_item(make_item(OP_CLEAR, SYM_W'($urandom), COLOR_W'($urandom),
                                INDEX_W'($urandom)));
         end else if (pick < 80) begin
            send_item(make_item(OP_UNUSED, SYM_W'($urandom), COLOR_W'($urandom),
                                INDEX_W'($urandom)));
         end else begin
            repeat ($urandom_range(1, 12)) put_byte(pick_glyph());
         end
      end
   endtask

   // response side: check every transaction, stall on a changing pattern
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_response({rsp_chan.cursor, rsp_chan.cell_symbol, rsp_chan.cell_color});
      rx_tick++;
      if (!hold_done && sb.checked >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 160);
         end
         mode_left--;
         case (rx_mode)
            RX_OPEN:   rsp_chan.ready <= 1'b1;
            RX_MOSTLY: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 4) == 0);
            default:   rsp_chan.ready <= (rx_tick % 7 < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles", quiet_cycles);
            $display("text_console_writer_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      req_chan.valid      = 1'b0;
      req_chan.operation  = '0;
      req_chan.symbol     = '0;
      req_chan.color      = '0;
      req_chan.cell_index = '0;
      burst_left = $urandom_range(1, 12);
      last_fill = FILL_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every operation, edge cases of the cursor
      read_cell(INDEX_W'(0));
      read_cell(INDEX_W'(SCREEN_CELLS - 1));
      read_cell(INDEX_W'(SCREEN_CELLS));
      read_cell(INDEX_W'(INDEX_MAX));
      send_item(make_item(OP_PUT, 8'h41, 8'h1f, '0));
      send_item(make_item(OP_PUT, 8'hff, 8'hff, '1));
      send_item(make_item(OP_PUT, CH_BLANK, 8'h00, '0));
      read_cell(INDEX_W'(2));
      send_item(make_item(OP_PUT, CH_BACKSPACE, 8'h70, '0));
      read_cell(INDEX_W'(2));
      send_item(make_item(OP_PUT, CH_NEWLINE, 8'h0f, '0));
      send_item(make_item(OP_PUT, 8'h7e, 8'h80, '0));
      send_item(make_item(OP_UNUSED, 8'hff, 8'hff, '1));
      send_item(make_item(OP_PUT, CH_BACKSPACE, 8'h34, '0));
      send_item(make_item(OP_PUT, CH_BACKSPACE, 8'hc5, '0));
      read_cell(INDEX_W'(COLS - 1));
      send_item(make_item(OP_CLEAR, 8'h00, 8'h00, '0));
      read_cell(INDEX_W'(COLS));
      send_item(make_item(OP_PUT, CH_BACKSPACE, 8'hff, '1));
      send_item(make_item(OP_PUT, CH_NEWLINE, 8'h00, '0));
      send_item(make_item(OP_PUT, CH_SPACE, 8'haa, '0));
      send_item(make_item(OP_UNUSED, 8'h00, 8'h00, '0));
      read_cell(INDEX_W'(1024));

      set_fill(8'hff);
      run_text(180);
      set_fill(8'h00);
      run_text(180);
      set_fill(COLOR_W'($urandom_range(1, 254)));
      run_text(190);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d requests, %0d scrolls, %0d clears, %0d reads (%0d off screen)",
               items_sent, sb.scrolls, sb.clears, sb.reads, sb.far_reads);
      $display("summary: fill colors 02 ff 00 %02h, %0d responses checked, %0d mismatches",
               last_fill, sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.replies.size() == 0) begin
         $display("text_console_writer_tb: PASS");
      end else begin
         $display("text_console_writer_tb: FAIL");
      end
      $finish;
   end
endmodule

// ===== text_console_writer.f =====
sv/tcw_pkg.sv
sv/tcw_req_if.sv
sv/tcw_rsp_if.sv
sv/tcw_cursor.sv
sv/tcw_engine.sv
sv/text_console_writer.sv
sv/tcw_checker.sv
verif/text_console_writer_tb.sv
